### rtl/two_cylinder_pneumatic_sequencer_core_defines.svh
// Assertion macros for the two-cylinder sequencer RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef TWO_CYLINDER_PNEUMATIC_SEQUENCER_CORE_DEFINES_SVH
`define TWO_CYLINDER_PNEUMATIC_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("tcps assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("tcps assertion failed");

`endif

### rtl/tcps_pkg.sv
// Shared types and constants for the two-cylinder pneumatic sequencer.
// No dependencies; imported by the cfg regs, phase logic and core.
`default_nettype none
package tcps_pkg;

  localparam int COUNT_BITS_DEF = 20;
  localparam int CFG_BITS       = 20;
  localparam int CFG_IDX_BITS   = 2;

  typedef enum logic [3:0] {
    PH_INIT  = 4'd0,
    PH_1     = 4'd1,
    PH_2     = 4'd2,
    PH_3     = 4'd3,
    PH_4     = 4'd4,
    PH_5     = 4'd5,
    PH_6     = 4'd6,
    PH_7     = 4'd7,
    PH_8     = 4'd8,
    PH_9     = 4'd9,
    PH_FATAL = 4'd10
  } phase_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_TIMEOUT_SHORT = 2'd0,
    CFG_TIMEOUT_LONG  = 2'd1,
    CFG_DELAY_SHORT   = 2'd2,
    CFG_DELAY_LONG    = 2'd3
  } cfg_idx_t;

  localparam logic [CFG_BITS-1:0] TIMEOUT_SHORT_RST = 20'd120000;
  localparam logic [CFG_BITS-1:0] TIMEOUT_LONG_RST  = 20'd200000;
  localparam logic [CFG_BITS-1:0] DELAY_SHORT_RST   = 20'd10;
  localparam logic [CFG_BITS-1:0] DELAY_LONG_RST    = 20'd60;

  typedef struct packed {
    logic [CFG_BITS-1:0] timeout_short;
    logic [CFG_BITS-1:0] timeout_long;
    logic [CFG_BITS-1:0] delay_short;
    logic [CFG_BITS-1:0] delay_long;
  } tcps_thr_t;

  typedef struct packed {
    phase_t phase;
    logic   first_drive;
    logic   second_drive;
  } tcps_ctl_t;

endpackage
`default_nettype wire

### rtl/tcps_if.sv
// Valid/ready channel interfaces for the sensor beat and the result beat.
// Depends on nothing but the standard logic type.
`default_nettype none
interface tcps_in_if;
  logic valid;
  logic ready;
  logic first_down;
  logic first_up;
  logic second_down;
  logic second_up;

  modport source (output valid, first_down, first_up, second_down, second_up,
                  input ready);
  modport sink   (input valid, first_down, first_up, second_down, second_up,
                  output ready);
endinterface

interface tcps_out_if;
  logic       valid;
  logic       ready;
  logic       first_valve;
  logic       second_valve;
  logic [3:0] phase_now;
  logic       running;

  modport source (output valid, first_valve, second_valve, phase_now, running,
                  input ready);
  modport sink   (input valid, first_valve, second_valve, phase_now, running,
                  output ready);
endinterface
`default_nettype wire

### rtl/tcps_cfg_regs.sv
// Threshold registers written through the plain configuration port.
// Depends on tcps_pkg.
`default_nettype none
module tcps_cfg_regs
  import tcps_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_idx,
  input  wire logic [CFG_BITS-1:0]     cfg_wdata,
  output tcps_thr_t                    thr
);

  tcps_thr_t thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.timeout_short <= TIMEOUT_SHORT_RST;
      thr_r.timeout_long  <= TIMEOUT_LONG_RST;
      thr_r.delay_short   <= DELAY_SHORT_RST;
      thr_r.delay_long    <= DELAY_LONG_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_TIMEOUT_SHORT: thr_r.timeout_short <= cfg_wdata;
        CFG_TIMEOUT_LONG:  thr_r.timeout_long  <= cfg_wdata;
        CFG_DELAY_SHORT:   thr_r.delay_short   <= cfg_wdata;
        CFG_DELAY_LONG:    thr_r.delay_long    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign thr = thr_r;

endmodule
`default_nettype wire

### rtl/tcps_phase_logic.sv
// Next-state logic for one tick: valve drives, phase step and counters.
// Depends on tcps_pkg; purely combinational.
`default_nettype none
module tcps_phase_logic
  import tcps_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire tcps_ctl_t        ctl,
  input  wire logic [COUNT_BITS-1:0] tcnt,
  input  wire logic [COUNT_BITS-1:0] dcnt,
  input  wire tcps_thr_t        thr,
  input  wire logic             first_down,
  input  wire logic             first_up,
  input  wire logic             second_down,
  input  wire logic             second_up,
  output tcps_ctl_t             ctl_nxt,
  output logic [COUNT_BITS-1:0] tcnt_nxt,
  output logic [COUNT_BITS-1:0] dcnt_nxt,
  output logic                  running
);

  localparam int CMP_BITS = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic                  active;
  logic                  cond;
  logic [CFG_BITS-1:0]   dly_thr;
  logic [CFG_BITS-1:0]   to_thr;
  phase_t                ph_next;
  phase_t                ph_fail;
  tcps_ctl_t             ctl_set;
  logic                  dly_over;
  logic                  to_over;
  logic [COUNT_BITS-1:0] tcnt_mid;
  logic [COUNT_BITS-1:0] dcnt_mid;

  // Per-phase table: drives on entry, awaited switches, thresholds, targets.
  always_comb begin
    active  = 1'b1;
    cond    = 1'b0;
    dly_thr = thr.delay_long;
    to_thr  = thr.timeout_short;
    ph_next = PH_FATAL;
    ph_fail = PH_FATAL;
    ctl_set = ctl;
    case (ctl.phase)
      PH_1: begin
        ctl_set.first_drive  = 1'b0;
        ctl_set.second_drive = 1'b0;
        cond    = first_down & second_down;
        dly_thr = thr.delay_short;
        ph_next = PH_2;
        ph_fail = PH_6;
      end
      PH_2: begin
        ctl_set.first_drive = 1'b1;
        cond    = first_up;
        ph_next = PH_3;
      end
      PH_3: begin
        ctl_set.second_drive = 1'b1;
        cond    = second_up;
        ph_next = PH_4;
      end
      PH_4: begin
        ctl_set.first_drive = 1'b0;
        cond    = first_down;
        dly_thr = thr.delay_short;
        ph_next = PH_5;
      end
      PH_5: begin
        ctl_set.second_drive = 1'b0;
        cond    = second_down;
        to_thr  = thr.timeout_long;
        ph_next = PH_6;
      end
      PH_6: begin
        ctl_set.first_drive  = 1'b1;
        ctl_set.second_drive = 1'b1;
        cond    = first_up & second_up;
        ph_next = PH_7;
      end
      PH_7: begin
        ctl_set.first_drive = 1'b0;
        cond    = first_down;
        to_thr  = thr.timeout_long;
        ph_next = PH_8;
      end
      PH_8: begin
        ctl_set.first_drive = 1'b1;
        cond    = first_up;
        ph_next = PH_9;
      end
      PH_9: begin
        ctl_set.first_drive = 1'b0;
        cond    = first_down;
        dly_thr = thr.delay_short;
        to_thr  = thr.timeout_long;
        ph_next = PH_1;
      end
      default: active = 1'b0;
    endcase
  end

  assign dly_over = CMP_BITS'(dcnt) > CMP_BITS'(dly_thr);
  assign to_over  = CMP_BITS'(tcnt) > CMP_BITS'(to_thr);

  always_comb begin
    running  = 1'b1;
    ctl_nxt  = ctl;
    tcnt_mid = tcnt;
    dcnt_mid = dcnt;
    if (ctl.phase == PH_INIT) begin
      ctl_nxt.phase = PH_1;
      tcnt_mid      = '0;
      dcnt_mid      = '0;
    end else if (!active) begin
      // fatal and unreachable codes: hold everything but the counters
      running = 1'b0;
    end else begin
      ctl_nxt = ctl_set;
      if (cond) begin
        tcnt_mid = '0;
        if (dly_over) begin
          ctl_nxt.phase = ph_next;
          dcnt_mid      = '0;
        end
      end else if (to_over) begin
        ctl_nxt.phase        = ph_fail;
        ctl_nxt.first_drive  = 1'b0;
        ctl_nxt.second_drive = 1'b0;
        tcnt_mid             = '0;
        dcnt_mid             = '0;
      end
    end
    tcnt_nxt = (tcnt_mid == CNT_MAX) ? tcnt_mid : tcnt_mid + 1'b1;
    dcnt_nxt = (dcnt_mid == CNT_MAX) ? dcnt_mid : dcnt_mid + 1'b1;
  end

endmodule
`default_nettype wire

### rtl/two_cylinder_pneumatic_sequencer_core.sv
// Usage
//   in_if  : one beat per tick carrying the four cylinder end switches.
//   out_if : one beat per accepted tick: valve drives, phase after the tick
//            and a running flag (0 when the tick was taken in the fatal phase).
//   cfg_*  : write-only threshold registers (timeout short/long, delay
//            short/long); write them only while no beat is in flight.
// Result beat registered: valid in the cycle after its tick is accepted.
// Throughput: one tick per cycle unless a result beat waits with out_if.ready
// low; the phase/counter update is a single pass of compare-and-count logic
// between the state registers and the result register.
// Stall: while a result beat waits in the output register and out_if.ready
// is low, in_if.ready drops; when out_if.ready is high a new tick is taken
// in the same cycle the waiting beat leaves.
// Reset (rst_n low, synchronous): init phase, counters and drives cleared,
// thresholds back to their defaults, no result pending. The fatal phase is
// left only through reset.
// Files: tcps_pkg, tcps_if, tcps_cfg_regs, tcps_phase_logic, defines header.
`default_nettype none
`include "two_cylinder_pneumatic_sequencer_core_defines.svh"
module two_cylinder_pneumatic_sequencer_core
  import tcps_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  tcps_in_if.sink                      in_if,
  tcps_out_if.source                   out_if,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_idx,
  input  wire logic [CFG_BITS-1:0]     cfg_wdata
);

  tcps_thr_t             thr;
  tcps_ctl_t             ctl_r;
  tcps_ctl_t             ctl_nxt;
  logic [COUNT_BITS-1:0] tcnt_r;
  logic [COUNT_BITS-1:0] tcnt_nxt;
  logic [COUNT_BITS-1:0] dcnt_r;
  logic [COUNT_BITS-1:0] dcnt_nxt;
  logic                  running_nxt;
  logic                  in_fire;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic                  first_valve_r;
  logic                  second_valve_r;
  logic [3:0]            phase_now_r;
  logic                  running_r;

  tcps_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .thr       (thr)
  );

  tcps_phase_logic #(
    .COUNT_BITS (COUNT_BITS)
  ) u_logic (
    .ctl         (ctl_r),
    .tcnt        (tcnt_r),
    .dcnt        (dcnt_r),
    .thr         (thr),
    .first_down  (in_if.first_down),
    .first_up    (in_if.first_up),
    .second_down (in_if.second_down),
    .second_up   (in_if.second_up),
    .ctl_nxt     (ctl_nxt),
    .tcnt_nxt    (tcnt_nxt),
    .dcnt_nxt    (dcnt_nxt),
    .running     (running_nxt)
  );

  // Take a tick whenever the result register is empty or draining this cycle.
  assign in_if.ready   = !out_valid_r || out_if.ready;
  assign in_fire       = in_if.valid && in_if.ready;
  assign out_valid_nxt = in_fire || (out_valid_r && !out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.phase        <= PH_INIT;
      ctl_r.first_drive  <= 1'b0;
      ctl_r.second_drive <= 1'b0;
      tcnt_r             <= '0;
      dcnt_r             <= '0;
      out_valid_r        <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        ctl_r  <= ctl_nxt;
        tcnt_r <= tcnt_nxt;
        dcnt_r <= dcnt_nxt;
      end
    end
  end

  // Result payload: load on accept, hold while stalled.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      first_valve_r  <= ctl_nxt.first_drive;
      second_valve_r <= ctl_nxt.second_drive;
      phase_now_r    <= ctl_nxt.phase;
      running_r      <= running_nxt;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.first_valve  = first_valve_r;
  assign out_if.second_valve = second_valve_r;
  assign out_if.phase_now    = phase_now_r;
  assign out_if.running      = running_r;

  `TCPS_ASSERT_NEXT(a_fatal_sticks, clk, rst_n,
    ctl_r.phase == PH_FATAL, ctl_r.phase == PH_FATAL)
  `TCPS_ASSERT_NOW(a_fatal_valves_off, clk, rst_n,
    ctl_r.phase == PH_FATAL, !ctl_r.first_drive && !ctl_r.second_drive)
  `TCPS_ASSERT_NEXT(a_fatal_tick_not_running, clk, rst_n,
    in_fire && ctl_r.phase == PH_FATAL, out_valid_r && !running_r)
  `TCPS_ASSERT_NEXT(a_init_goes_to_one, clk, rst_n,
    in_fire && ctl_r.phase == PH_INIT,
    ctl_r.phase == PH_1 && tcnt_r == COUNT_BITS'(1) && dcnt_r == COUNT_BITS'(1))

endmodule
`default_nettype wire

### tb/two_cylinder_pneumatic_sequencer_core_tb.sv
// Self-checking bench for the two-cylinder pneumatic sequencer core.
// Drives end-switch beats from a table, then from a cylinder plant driven by the predicted valves.
// Depends on tcps_pkg, tcps_if and the core RTL.
module two_cylinder_pneumatic_sequencer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tcps_pkg::*;

  localparam int COUNT_W    = COUNT_BITS_DEF;
  localparam int LONG_STALL = 40;
  localparam int DIR_ROWS   = 24;
  localparam logic [CFG_BITS-1:0] THR_MAX = '1;

  typedef struct packed {
    logic first_down;
    logic first_up;
    logic second_down;
    logic second_up;
  } switch_beat_t;

  typedef struct packed {
    logic   first_valve;
    logic   second_valve;
    phase_t phase_now;
    logic   running;
  } valve_beat_t;

  typedef struct {
    switch_beat_t switches;
    bit           typed;
    valve_beat_t  result;
  } dir_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    cfg_we;
  cfg_idx_t                cfg_idx;
  logic [CFG_BITS-1:0]     cfg_wdata;

  tcps_in_if  in_if ();
  tcps_out_if out_if ();

  two_cylinder_pneumatic_sequencer_core #(
    .COUNT_BITS(COUNT_W)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .out_if   (out_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // Sequencer copy: thresholds, phase, counters and valve drives.
  logic [CFG_BITS-1:0] thr_tmo_short, thr_tmo_long, thr_dly_short, thr_dly_long;
  phase_t              seq_phase;
  logic [COUNT_W-1:0]  tmo_cnt, dly_cnt;
  logic                first_drv, second_drv;

  valve_beat_t pending_results[$];
  dir_row_t    dir_rows[DIR_ROWS];
  int          fail_count = 0;
  int          jam_left;
  bit          rx_idle_on;
  bit          long_stall_req;

  function automatic valve_beat_t advance_sequencer(switch_beat_t sw);
    valve_beat_t         r;
    logic                hold;
    logic [CFG_BITS-1:0] dly_thr, tmo_thr;
    phase_t              on_pass, on_fail;
    bit                  in_seq;
    hold    = 1'b0;
    dly_thr = thr_dly_short;
    tmo_thr = thr_tmo_short;
    on_pass = PH_1;
    on_fail = PH_FATAL;
    in_seq  = 1'b1;
    r.running = 1'b1;
    case (seq_phase)
      PH_INIT: begin
        seq_phase = PH_1;
        dly_cnt   = '0;
        tmo_cnt   = '0;
        in_seq    = 1'b0;
      end
      PH_1: begin
        first_drv  = 1'b0;
        second_drv = 1'b0;
        hold       = sw.first_down & sw.second_down;
        on_pass    = PH_2;
        on_fail    = PH_6;
      end
      PH_2: begin
        first_drv = 1'b1;
        hold      = sw.first_up;
        dly_thr   = thr_dly_long;
        on_pass   = PH_3;
      end
      PH_3: begin
        second_drv = 1'b1;
        hold       = sw.second_up;
        dly_thr    = thr_dly_long;
        on_pass    = PH_4;
      end
      PH_4: begin
        first_drv = 1'b0;
        hold      = sw.first_down;
        on_pass   = PH_5;
      end
      PH_5: begin
        second_drv = 1'b0;
        hold       = sw.second_down;
        dly_thr    = thr_dly_long;
        tmo_thr    = thr_tmo_long;
        on_pass    = PH_6;
      end
      PH_6: begin
        first_drv  = 1'b1;
        second_drv = 1'b1;
        hold       = sw.first_up & sw.second_up;
        dly_thr    = thr_dly_long;
        on_pass    = PH_7;
      end
      PH_7: begin
        first_drv = 1'b0;
        hold      = sw.first_down;
        dly_thr   = thr_dly_long;
        tmo_thr   = thr_tmo_long;
        on_pass   = PH_8;
      end
      PH_8: begin
        first_drv = 1'b1;
        hold      = sw.first_up;
        dly_thr   = thr_dly_long;
        on_pass   = PH_9;
      end
      PH_9: begin
        first_drv = 1'b0;
        hold      = sw.first_down;
        tmo_thr   = thr_tmo_long;
        on_pass   = PH_1;
      end
      default: begin
        in_seq    = 1'b0;
        r.running = 1'b0;
      end
    endcase
    if (in_seq) begin
      if (hold) begin
        tmo_cnt = '0;
        if (dly_cnt > dly_thr) begin
          seq_phase = on_pass;
          dly_cnt   = '0;
        end
      end else if (tmo_cnt > tmo_thr) begin
        seq_phase  = on_fail;
        first_drv  = 1'b0;
        second_drv = 1'b0;
        dly_cnt    = '0;
        tmo_cnt    = '0;
      end
    end
    if (tmo_cnt != '1) tmo_cnt = tmo_cnt + 1'b1;
    if (dly_cnt != '1) dly_cnt = dly_cnt + 1'b1;
    r.first_valve  = first_drv;
    r.second_valve = second_drv;
    r.phase_now    = seq_phase;
    return r;
  endfunction

  // Plant: switches follow the valves with one beat of lag, plus noise and
  // stuck-cylinder episodes in phase 1 long enough to trip its timeout.
  function automatic switch_beat_t next_switches(int noise_pct, int jam_pct);
    switch_beat_t sw;
    if (seq_phase != PH_1) begin
      jam_left = 0;
    end else if (jam_left == 0 && $urandom_range(0, 99) < jam_pct) begin
      jam_left = int'(thr_tmo_short) + 3;
    end
    if (jam_left > 0) begin
      jam_left--;
      sw = '0;
    end else if ($urandom_range(0, 99) < noise_pct) begin
      sw = switch_beat_t'($urandom_range(0, 15));
    end else begin
      sw = '{first_down: ~first_drv, first_up: first_drv,
             second_down: ~second_drv, second_up: second_drv};
    end
    return sw;
  endfunction

  task automatic run_ticks(input int count, input int noise_pct, input int jam_pct,
                           input bit gaps_on, input bit from_table);
    int           sent;
    int           gap_left;
    switch_beat_t sw;
    valve_beat_t  r;
    sent     = 0;
    gap_left = 0;
    while (sent < count) begin
      @(posedge clk);
      if (in_if.valid && in_if.ready) begin
        sw = '{first_down: in_if.first_down, first_up: in_if.first_up,
               second_down: in_if.second_down, second_up: in_if.second_up};
        r = advance_sequencer(sw);
        if (from_table && dir_rows[sent].typed) r = dir_rows[sent].result;
        pending_results.push_back(r);
        sent++;
      end else if (in_if.valid) begin
        continue;  // hold the beat until taken
      end
      if (sent == count) begin
        in_if.valid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(1, 5) - 1;
        in_if.valid <= 1'b0;
      end else begin
        sw = from_table ? dir_rows[sent].switches : next_switches(noise_pct, jam_pct);
        in_if.first_down  <= sw.first_down;
        in_if.first_up    <= sw.first_up;
        in_if.second_down <= sw.second_down;
        in_if.second_up   <= sw.second_up;
        in_if.valid       <= 1'b1;
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_BITS-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_TIMEOUT_SHORT: thr_tmo_short = val;
      CFG_TIMEOUT_LONG:  thr_tmo_long  = val;
      CFG_DELAY_SHORT:   thr_dly_short = val;
      CFG_DELAY_LONG:    thr_dly_long  = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_thresholds(input logic [CFG_BITS-1:0] tmo_s, input logic [CFG_BITS-1:0] tmo_l,
                                input logic [CFG_BITS-1:0] dly_s, input logic [CFG_BITS-1:0] dly_l);
    wait_drained();
    write_reg(CFG_TIMEOUT_SHORT, tmo_s);
    write_reg(CFG_TIMEOUT_LONG, tmo_l);
    write_reg(CFG_DELAY_SHORT, dly_s);
    write_reg(CFG_DELAY_LONG, dly_l);
  endtask

  // Result side: check each beat against the oldest expectation, stall at random or on a long-stall request.
  always @(posedge clk) begin
    valve_beat_t want;
    int          stall_left;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_if.first_valve !== want.first_valve) begin
          $error("first_valve: expected %0d, got %0d", want.first_valve, out_if.first_valve);
          fail_count++;
        end
        if (out_if.second_valve !== want.second_valve) begin
          $error("second_valve: expected %0d, got %0d", want.second_valve, out_if.second_valve);
          fail_count++;
        end
        if (out_if.phase_now !== want.phase_now) begin
          $error("phase_now: expected %0d, got %0d", want.phase_now, out_if.phase_now);
          fail_count++;
        end
        if (out_if.running !== want.running) begin
          $error("running: expected %0d, got %0d", want.running, out_if.running);
          fail_count++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (long_stall_req) begin
      long_stall_req = 1'b0;
      stall_left     = LONG_STALL - 1;
      out_if.ready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 5) - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_TIMEOUT_SHORT;
    cfg_wdata         = '0;
    in_if.valid       = 1'b0;
    in_if.first_down  = 1'b0;
    in_if.first_up    = 1'b0;
    in_if.second_down = 1'b0;
    in_if.second_up   = 1'b0;
    out_if.ready      = 1'b0;
    rx_idle_on        = 1'b1;
    long_stall_req    = 1'b0;
    jam_left          = 0;

    thr_tmo_short = TIMEOUT_SHORT_RST;
    thr_tmo_long  = TIMEOUT_LONG_RST;
    thr_dly_short = DELAY_SHORT_RST;
    thr_dly_long  = DELAY_LONG_RST;
    seq_phase     = PH_INIT;
    tmo_cnt       = '0;
    dly_cnt       = '0;
    first_drv     = 1'b0;
    second_drv    = 1'b0;

    // Every switch combination, then first_up held. The init beat and the next
    // few stay in phase 1 with both valves off, well short of the delay.
    foreach (dir_rows[i]) begin
      dir_rows[i].typed  = (i < 5);
      dir_rows[i].result = '{first_valve: 1'b0, second_valve: 1'b0,
                             phase_now: PH_1, running: 1'b1};
      if (i < 16) dir_rows[i].switches = switch_beat_t'(4'(i));
      else dir_rows[i].switches = '{first_down: 1'b0, first_up: 1'b1,
                                    second_down: 1'b0, second_up: 1'b0};
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    run_ticks(DIR_ROWS, 0, 0, 1'b1, 1'b1);

    // Zero settle delays: advance on the first beat after entry.
    set_thresholds(20'd20, 20'd30, 20'd0, 20'd0);
    run_ticks(120, 10, 15, 1'b1, 1'b0);

    set_thresholds(20'($urandom_range(15, 30)), 20'($urandom_range(20, 40)),
                   20'($urandom_range(1, 4)), 20'($urandom_range(2, 6)));
    run_ticks(60, 8, 10, 1'b1, 1'b0);
    long_stall_req = 1'b1;  // fill the core and back up the input
    run_ticks(60, 8, 10, 1'b1, 1'b0);
    wait_drained();
    run_ticks(30, 8, 10, 1'b1, 1'b0);

    // Thresholds out of reach: no advance on the short delay, no timeout at all.
    set_thresholds(THR_MAX, THR_MAX, THR_MAX, 20'd1);
    run_ticks(80, 50, 0, 1'b1, 1'b0);

    rx_idle_on = 1'b0;
    set_thresholds(20'($urandom_range(12, 30)), 20'($urandom_range(20, 40)),
                   20'($urandom_range(0, 3)), 20'($urandom_range(1, 5)));
    run_ticks(150, 5, 10, 1'b0, 1'b0);

    // Zero timeouts: drop into fatal and stay there.
    set_thresholds(20'd0, 20'd0, 20'd2, 20'd2);
    run_ticks(30, 20, 0, 1'b0, 1'b0);

    wait_drained();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("two_cylinder_pneumatic_sequencer_core test passed");
    end else begin
      $display("two_cylinder_pneumatic_sequencer_core test failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("two_cylinder_pneumatic_sequencer_core test failed");
    $finish;
  end

endmodule
